/* hw/rtl/lzd_pkg.sv */
// lzd_pkg: types and constants shared by the lz77 triplet decoder
// no dependencies
`default_nettype none

package lzd_pkg;

  localparam int OffsetW = 13;
  localparam int LengthW = 4;
  localparam int ByteW   = 8;

  typedef struct packed {
    logic [OffsetW-1:0] back_offset;
    logic [LengthW-1:0] match_length;
    logic [ByteW-1:0]   next_byte;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic             bad_reference;
  } out_t;

  // classified triplet handed from front end to back end
  typedef struct packed {
    logic [OffsetW-1:0] back_offset;
    logic [LengthW-1:0] copy_len;
    logic [ByteW-1:0]   next_byte;
    logic               bad_reference;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/lzd_front.sv */
// lzd_front: accepts triplets, caps the length and checks the reference
// against the projected history fill; depends on lzd_pkg
`default_nettype none

module lzd_front import lzd_pkg::*; #(
  parameter int WINDOW_SIZE    = 4096,
  parameter int LOOKAHEAD_SIZE = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_payload,
  output logic      push_valid,
  input  wire logic push_ready,
  output cmd_t      push_cmd
);

  localparam int FillW = $clog2(WINDOW_SIZE + 1);
  localparam int CmpW  = (FillW > OffsetW) ? FillW + 1 : OffsetW + 1;
  localparam int CapI  = (LOOKAHEAD_SIZE - 1 < 15) ? LOOKAHEAD_SIZE - 1 : 15;
  localparam logic [LengthW-1:0] Cap = LengthW'(CapI);

  logic [FillW-1:0]   fill_r, fill_nxt;
  logic [LengthW-1:0] eff_len;
  logic               bad;
  logic [CmpW-1:0]    sum;

  assign eff_len = (in_payload.match_length > Cap) ? Cap : in_payload.match_length;

  assign bad = (eff_len != '0) &&
               ((in_payload.back_offset == '0) ||
                (CmpW'(in_payload.back_offset) > CmpW'(fill_r)));

  assign push_cmd.back_offset   = in_payload.back_offset;
  assign push_cmd.copy_len      = bad ? '0 : eff_len;
  assign push_cmd.next_byte     = in_payload.next_byte;
  assign push_cmd.bad_reference = bad;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // saturating count of bytes that the back end will have written
  assign sum = CmpW'(fill_r) + CmpW'(push_cmd.copy_len) + CmpW'(1);

  always_comb begin
    fill_nxt = fill_r;
    if (in_valid && push_ready) begin
      if (sum >= CmpW'(WINDOW_SIZE)) begin
        fill_nxt = FillW'(WINDOW_SIZE);
      end else begin
        fill_nxt = sum[FillW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lzd_queue.sv */
// lzd_queue: two-entry command queue between front and back end
// depends on lzd_pkg
`default_nettype none

module lzd_queue import lzd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lzd_back.sv */
// lzd_back: copies match bytes from the history ring and emits the literal
// holds the history memory and the output register; depends on lzd_pkg
`default_nettype none

module lzd_back import lzd_pkg::*; #(
  parameter int WINDOW_SIZE = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  output logic      pop_ready,
  input  wire cmd_t pop_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_payload
);

  localparam int AddrW = $clog2(WINDOW_SIZE);
  localparam int SubW  = (AddrW + 1 > OffsetW + 1) ? AddrW + 1 : OffsetW + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WINDOW_SIZE - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_LIT  = 2'd2;

  logic [ByteW-1:0] hist_mem [WINDOW_SIZE];

  logic [1:0]         state_r, state_nxt;
  logic [AddrW-1:0]   wp_r, wp_nxt;
  logic [AddrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LengthW-1:0] reads_left_r, reads_left_nxt;
  logic [LengthW-1:0] copies_left_r, copies_left_nxt;
  logic               off_one_r, off_one_nxt;
  logic [ByteW-1:0]   lit_r, lit_nxt;
  logic               bad_r, bad_nxt;
  logic               rdv_r, rdv_nxt;
  logic [ByteW-1:0]   mem_q_r;
  logic [ByteW-1:0]   last_byte_r, last_byte_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic             can_load, src_avail, copy_emit, lit_emit, issue, wr_en;
  logic [ByteW-1:0] src_byte, wr_byte;
  logic [SubW-1:0]  start_sum;
  logic [AddrW-1:0] start_addr;

  assign can_load  = !out_valid_r || out_ready;
  assign src_avail = off_one_r || rdv_r;
  assign src_byte  = off_one_r ? last_byte_r : mem_q_r;
  assign copy_emit = (state_r == ST_COPY) && src_avail && can_load;
  assign lit_emit  = (state_r == ST_LIT) && can_load;
  assign issue     = (state_r == ST_COPY) && !off_one_r && (reads_left_r != '0) &&
                     (!rdv_r || copy_emit);
  assign wr_en     = copy_emit || lit_emit;
  assign wr_byte   = copy_emit ? src_byte : lit_r;
  assign pop_ready = (state_r == ST_IDLE);

  // start of the match, offset bytes behind the write pointer, wrapped
  always_comb begin
    start_sum = SubW'(wp_r) - SubW'(pop_cmd.back_offset);
    if (SubW'(wp_r) < SubW'(pop_cmd.back_offset)) begin
      start_sum = SubW'(wp_r) + SubW'(WINDOW_SIZE) - SubW'(pop_cmd.back_offset);
    end
    start_addr = start_sum[AddrW-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    rd_ptr_nxt      = rd_ptr_r;
    reads_left_nxt  = reads_left_r;
    copies_left_nxt = copies_left_r;
    off_one_nxt     = off_one_r;
    lit_nxt         = lit_r;
    bad_nxt         = bad_r;
    rdv_nxt         = rdv_r;
    wp_nxt          = wp_r;
    last_byte_nxt   = last_byte_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          off_one_nxt     = (pop_cmd.back_offset == OffsetW'(1));
          copies_left_nxt = pop_cmd.copy_len;
          reads_left_nxt  = pop_cmd.copy_len;
          rd_ptr_nxt      = start_addr;
          lit_nxt         = pop_cmd.next_byte;
          bad_nxt         = pop_cmd.bad_reference;
          state_nxt       = (pop_cmd.copy_len != '0) ? ST_COPY : ST_LIT;
        end
      end
      ST_COPY: begin
        if (issue) begin
          rd_ptr_nxt     = (rd_ptr_r == LastAddr) ? '0 : rd_ptr_r + AddrW'(1);
          reads_left_nxt = reads_left_r - LengthW'(1);
        end
        rdv_nxt = issue ? 1'b1 : (copy_emit ? 1'b0 : rdv_r);
        if (copy_emit) begin
          copies_left_nxt = copies_left_r - LengthW'(1);
          if (copies_left_r == LengthW'(1)) begin
            state_nxt = ST_LIT;
          end
        end
      end
      ST_LIT: begin
        if (lit_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (wr_en) begin
      wp_nxt        = (wp_r == LastAddr) ? '0 : wp_r + AddrW'(1);
      last_byte_nxt = wr_byte;
    end

    if (can_load) begin
      out_valid_nxt = wr_en;
      if (wr_en) begin
        out_nxt.data_byte     = wr_byte;
        out_nxt.last          = lit_emit;
        out_nxt.bad_reference = lit_emit && bad_r;
      end
    end
  end

  // history ring: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= wr_byte;
    end
    if (issue) begin
      mem_q_r <= hist_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r      <= rd_ptr_nxt;
    reads_left_r  <= reads_left_nxt;
    copies_left_r <= copies_left_nxt;
    off_one_r     <= off_one_nxt;
    lit_r         <= lit_nxt;
    bad_r         <= bad_nxt;
    last_byte_r   <= last_byte_nxt;
    out_r         <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

/* hw/rtl/lz77_triplet_decoder.sv */
// lz77_triplet_decoder: front end, two-entry command queue, copy back end
// path: front end classifies combinationally, queue registers each command, back end
// loads it when idle and drives an output register; offset one skips the ring read
// back end: takes a new triplet only after emitting the last one's closing literal;
// at most one copied byte per cycle while the output is not stalled
// reset: synchronous active-low rst_n empties the queue and history; ring contents kept
// depends on lzd_pkg, lzd_front, lzd_queue, lzd_back
`default_nettype none

module lz77_triplet_decoder import lzd_pkg::*; #(
  parameter int WINDOW_SIZE    = 4096,
  parameter int LOOKAHEAD_SIZE = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_payload,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_payload
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  lzd_front #(
    .WINDOW_SIZE   (WINDOW_SIZE),
    .LOOKAHEAD_SIZE(LOOKAHEAD_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_payload(in_payload),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  lzd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  lzd_back #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

endmodule

`default_nettype wire

/* hw/rtl/lzd_checker.sv */
// lzd_checker: port-level checks on the decoder's channels, bound to the top
// depends on lzd_pkg and lz77_triplet_decoder
`default_nettype none

module lzd_checker import lzd_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire in_t  in_payload,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_payload
);

  // a waiting input transfer keeps its triplet
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_payload))
    else $error("input changed while waiting");

  // a stalled transfer keeps its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("output changed while stalled");

  // a rejected reference is only ever flagged on the closing literal
  a_bad_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_payload.bad_reference || out_payload.last))
    else $error("bad reference flagged on a copied byte");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lz77_triplet_decoder lzd_checker u_lzd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_payload (in_payload),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_payload(out_payload)
);

`default_nettype wire
